### hdl/wst_pkg.sv
// shared types, constants and the generator step for the work-stealing scheduler
package wst_pkg;

  localparam int unsigned RNG_W = 64;
  localparam logic [RNG_W-1:0] RNG_SEED_BASIS = 64'h9e3779b97f4a7c15;
  localparam int unsigned RNG_SHIFT_A = 13;
  localparam int unsigned RNG_SHIFT_B = 7;
  localparam int unsigned RNG_SHIFT_C = 17;
  localparam logic [7:0] PENDING_MAX = 8'd255;

  typedef enum logic [1:0] {
    K_SUBMIT = 2'd0,
    K_FETCH  = 2'd1,
    K_FINISH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_OWN       = 3'd2,
    ST_STOLEN    = 3'd3,
    ST_NO_WORK   = 3'd4,
    ST_DONE      = 3'd5,
    ST_UNDERFLOW = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUSH,
    S_SLIDE_RD,
    S_SLIDE_WR,
    S_DIV,
    S_SCAN,
    S_READ,
    S_OUT
  } state_e;

  function automatic logic [RNG_W-1:0] xorshift_step(input logic [RNG_W-1:0] r);
    logic [RNG_W-1:0] x;
    x = r;
    x = x ^ (x << RNG_SHIFT_A);
    x = x ^ (x >> RNG_SHIFT_B);
    x = x ^ (x << RNG_SHIFT_C);
    return x;
  endfunction

endpackage

### hdl/work_stealing_task_scheduler.sv
// work-stealing scheduler: per-worker task queues, sequencer and result register
// finish and a fetch with no peer to scan go from dispatch to the output state,
// a submit via the push state, an own fetch via the read state; a submit to a
// full-at-end queue first compacts it, a scanning fetch first waits on the 64-step
// serial remainder unit; the next item is accepted in the cycle after the result is
// loaded; reset: all queues empty, round-robin pointer and pending count zero, worker
// count WORKERS, generators seeded; no clearing pass, the store is never read unwritten
module work_stealing_task_scheduler
  import wst_pkg::*;
#(
  parameter int unsigned WORKERS     = 8,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TASK_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  active_workers_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  worker_id_i,
  input  logic [31:0] task_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] task_out_o,
  output logic [2:0]  source_worker_o,
  output logic [7:0]  pending_count_o,
  output logic        all_done_o
);

  localparam int unsigned WW      = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned CW      = $clog2(WORKERS + 1);
  localparam int unsigned QW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRIES = WORKERS * QUEUE_DEPTH;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam logic [QW-1:0] QD    = QW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] slot_addr(input logic [WW-1:0] w,
                                             input logic [QW-1:0] idx);
    return AW'(32'(w) * QUEUE_DEPTH + 32'(idx));
  endfunction

  state_e state_q, state_d;

  logic [CW-1:0]        cnt_q;
  logic [7:0]           cfg_ext;
  logic [1:0]           kind_q, kind_d;
  logic [2:0]           wid_q, wid_d;
  logic [TASK_BITS-1:0] hnd_q, hnd_d;
  logic [WW-1:0]        nt_q, nt_d;
  logic [WW-1:0]        cur_q, cur_d;
  logic [QW-1:0]        k_q, k_d;
  logic [CW-1:0]        start_q, start_d;
  logic [CW-1:0]        off_q, off_d;
  logic [7:0]           pend_q, pend_d;
  status_e              res_status_q, res_status_d;
  logic [31:0]          res_task_q, res_task_d;
  logic [2:0]           res_src_q, res_src_d;
  logic                 res_done_q, res_done_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           o_status_q, o_status_d;
  logic [31:0]          o_task_q, o_task_d;
  logic [2:0]           o_src_q, o_src_d;
  logic [7:0]           o_pend_q, o_pend_d;
  logic                 o_done_q, o_done_d;

  logic [QW-1:0]    head_q [WORKERS];
  logic [QW-1:0]    tail_q [WORKERS];
  logic [RNG_W-1:0] rng_q  [WORKERS];

  logic             head_we, tail_we, rng_we;
  logic [QW-1:0]    head_wv, tail_wv;
  logic [RNG_W-1:0] rng_wv;

  logic [WW-1:0]        sel_w;
  logic [QW-1:0]        hd, tl;
  logic [WW-1:0]        tgt, wid_w, vic;
  logic [CW:0]          vsum;
  logic                 wid_ok;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [TASK_BITS-1:0] ram_wdata, ram_rdata;
  logic                 div_start, div_done;
  logic [CW-1:0]        div_rem;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = {4'b0, active_workers_i};

  // worker count is kept clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(WORKERS);
    end else if (cfg_valid_i) begin
      if (cfg_ext == 8'd0) begin
        cnt_q <= CW'(1);
      end else if (cfg_ext > 8'(WORKERS)) begin
        cnt_q <= CW'(WORKERS);
      end else begin
        cnt_q <= CW'(cfg_ext);
      end
    end
  end

  assign tgt    = (8'(nt_q) < 8'(cnt_q)) ? nt_q : '0;
  assign wid_w  = WW'(wid_q);
  assign wid_ok = 8'(wid_q) < 8'(cnt_q);
  assign vsum   = (CW+1)'(start_q) + (CW+1)'(off_q);
  assign vic    = (vsum >= (CW+1)'(cnt_q)) ? WW'(vsum - (CW+1)'(cnt_q)) : WW'(vsum);

  // single read point on the queue index registers
  always_comb begin
    case (state_q)
      S_DISPATCH: sel_w = (kind_q == K_SUBMIT) ? tgt : wid_w;
      S_SCAN:     sel_w = vic;
      default:    sel_w = cur_q;
    endcase
  end

  assign hd = head_q[sel_w];
  assign tl = tail_q[sel_w];

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    wid_d        = wid_q;
    hnd_d        = hnd_q;
    nt_d         = nt_q;
    cur_d        = cur_q;
    k_d          = k_q;
    start_d      = start_q;
    off_d        = off_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_task_d   = res_task_q;
    res_src_d    = res_src_q;
    res_done_d   = res_done_q;
    out_valid_d  = out_valid_q;
    o_status_d   = o_status_q;
    o_task_d     = o_task_q;
    o_src_d      = o_src_q;
    o_pend_d     = o_pend_q;
    o_done_d     = o_done_q;
    head_we      = 1'b0;
    head_wv      = '0;
    tail_we      = 1'b0;
    tail_wv      = '0;
    rng_we       = 1'b0;
    rng_wv       = xorshift_step(rng_q[sel_w]);
    ram_we       = 1'b0;
    ram_waddr    = slot_addr(cur_q, tl);
    ram_wdata    = hnd_q;
    ram_raddr    = slot_addr(cur_q, QW'(hd + k_q));
    div_start    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d       = kind_i;
          wid_d        = worker_id_i;
          hnd_d        = TASK_BITS'(task_handle_i);
          res_status_d = ST_NO_WORK;
          res_task_d   = '0;
          res_src_d    = '0;
          res_done_d   = 1'b0;
          state_d      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_OUT;
        case (kind_q)
          K_SUBMIT: begin
            nt_d      = ((8'(tgt) + 8'd1) >= 8'(cnt_q)) ? '0 : WW'(tgt + 1'b1);
            res_src_d = 3'(tgt);
            cur_d     = tgt;
            if (hd == tl) begin
              head_we = 1'b1;
              tail_we = 1'b1;
              state_d = S_PUSH;
            end else if (tl < QD) begin
              state_d = S_PUSH;
            end else if (hd != '0) begin
              // compact the live entries to the front first
              k_d     = '0;
              state_d = S_SLIDE_RD;
            end else begin
              res_status_d = ST_FULL;
            end
          end
          K_FETCH: begin
            if (wid_ok) begin
              if (tl > hd && tl <= QD) begin
                tail_we      = 1'b1;
                tail_wv      = QW'(tl - 1'b1);
                ram_raddr    = slot_addr(wid_w, QW'(tl - 1'b1));
                res_status_d = ST_OWN;
                res_src_d    = wid_q;
                state_d      = S_READ;
              end else if (cnt_q > CW'(1)) begin
                rng_we    = 1'b1;
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
          end
          K_FINISH: begin
            if (pend_q == 8'd0) begin
              res_status_d = ST_UNDERFLOW;
            end else begin
              pend_d       = pend_q - 1'b1;
              res_status_d = ST_DONE;
              res_done_d   = (pend_q == 8'd1);
            end
          end
          default: begin
            res_status_d = ST_NO_WORK;
          end
        endcase
      end
      S_PUSH: begin
        ram_we       = 1'b1;
        ram_waddr    = slot_addr(cur_q, tl);
        tail_we      = 1'b1;
        tail_wv      = QW'(tl + 1'b1);
        res_status_d = ST_ACCEPTED;
        if (pend_q < PENDING_MAX) begin
          pend_d = pend_q + 1'b1;
        end
        state_d = S_OUT;
      end
      S_SLIDE_RD: begin
        state_d = S_SLIDE_WR;
      end
      S_SLIDE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(cur_q, k_q);
        ram_wdata = ram_rdata;
        if (QW'(k_q + 1'b1) == QW'(tl - hd)) begin
          head_we = 1'b1;
          tail_we = 1'b1;
          tail_wv = QW'(tl - hd);
          state_d = S_PUSH;
        end else begin
          k_d     = QW'(k_q + 1'b1);
          state_d = S_SLIDE_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          start_d = div_rem;
          off_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (off_q == cnt_q) begin
          state_d = S_OUT;
        end else if (vic == wid_w) begin
          off_d = CW'(off_q + 1'b1);
        end else if (hd < tl && hd < QD) begin
          ram_raddr    = slot_addr(vic, hd);
          head_we      = 1'b1;
          head_wv      = QW'(hd + 1'b1);
          res_status_d = ST_STOLEN;
          res_src_d    = 3'(vic);
          state_d      = S_READ;
        end else begin
          off_d = CW'(off_q + 1'b1);
        end
      end
      S_READ: begin
        res_task_d = 32'(ram_rdata);
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_status_d  = res_status_q;
          o_task_d    = res_task_q;
          o_src_d     = res_src_q;
          o_pend_d    = pend_q;
          o_done_d    = res_done_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nt_q        <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nt_q        <= nt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    wid_q        <= wid_d;
    hnd_q        <= hnd_d;
    cur_q        <= cur_d;
    k_q          <= k_d;
    start_q      <= start_d;
    off_q        <= off_d;
    res_status_q <= res_status_d;
    res_task_q   <= res_task_d;
    res_src_q    <= res_src_d;
    res_done_q   <= res_done_d;
    o_status_q   <= o_status_d;
    o_task_q     <= o_task_d;
    o_src_q      <= o_src_d;
    o_pend_q     <= o_pend_d;
    o_done_q     <= o_done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < WORKERS; w++) begin
        head_q[w] <= '0;
        tail_q[w] <= '0;
        rng_q[w]  <= RNG_SEED_BASIS ^ RNG_W'(w + 1);
      end
    end else begin
      if (head_we) begin
        head_q[sel_w] <= head_wv;
      end
      if (tail_we) begin
        tail_q[sel_w] <= tail_wv;
      end
      if (rng_we) begin
        rng_q[sel_w] <= rng_wv;
      end
    end
  end

  wst_task_ram #(
    .ENTRIES (ENTRIES),
    .WIDTH   (TASK_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wst_mod_unit #(
    .DIV_W (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rng_wv),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign task_out_o      = o_task_q;
  assign source_worker_o = o_src_q;
  assign pending_count_o = o_pend_q;
  assign all_done_o      = o_done_q;

endmodule

### hdl/wst_mod_unit.sv
// bit-serial remainder unit: 64-bit generator value modulo the worker count
module wst_mod_unit
  import wst_pkg::*;
#(
  parameter int unsigned DIV_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RNG_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(RNG_W);

  logic [RNG_W-1:0] dvd_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DIV_W:0]   shifted;

  assign shifted = {rem_q, dvd_q[RNG_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RNG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle while busy, only the remainder is kept
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (shifted >= {1'b0, dvs_q}) begin
        rem_q <= DIV_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_q <= DIV_W'(shifted);
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/wst_task_ram.sv
// task handle store: one write port, one registered read port
module wst_task_ram #(
  parameter int unsigned ENTRIES = 128,
  parameter int unsigned WIDTH   = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem [ENTRIES];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/work_stealing_task_scheduler_tb.sv
// self-checking testbench for the work-stealing task scheduler
`timescale 1ns / 100ps

module work_stealing_task_scheduler_tb
  import wst_pkg::*;
();

  localparam int unsigned NW = 8;
  localparam int unsigned QD = 16;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  wid;
    logic [31:0] handle;
  } sched_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] task_val;
    logic [2:0]  src;
    logic [7:0]  pending;
    logic        done;
  } sched_rsp_t;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_workers;
  logic        in_valid, in_ready;
  logic [1:0]  kind;
  logic [2:0]  worker_id;
  logic [31:0] task_handle;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [31:0] task_out;
  logic [2:0]  source_worker;
  logic [7:0]  pending_count;
  logic        all_done;

  work_stealing_task_scheduler dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .active_workers_i(cfg_workers),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .worker_id_i(worker_id), .task_handle_i(task_handle),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .task_out_o(task_out), .source_worker_o(source_worker),
    .pending_count_o(pending_count), .all_done_o(all_done)
  );

  // scheduler shadow state
  logic [31:0] sh_store [NW][QD];
  int unsigned sh_head [NW];
  int unsigned sh_tail [NW];
  logic [63:0] sh_rng [NW];
  int unsigned sh_next;
  int unsigned sh_pending;
  logic [3:0]  sh_workers;

  sched_req_t  pending_reqs[$];
  sched_rsp_t  expected_rsps[$];
  int unsigned errors, checked, steals, fulls, cycles;
  bit          calm;
  int unsigned in_gap, out_gap;

  function automatic int unsigned live_workers();
    if (sh_workers == 0) return 1;
    if (sh_workers > NW) return NW;
    return sh_workers;
  endfunction

  function automatic sched_rsp_t schedule_item(sched_req_t rq);
    sched_rsp_t  r;
    int unsigned cnt, t, hd, tl, st, v;
    logic [63:0] x;
    r = '0;
    r.status = ST_NO_WORK;
    cnt = live_workers();
    if (rq.kind == K_SUBMIT) begin
      t = (sh_next < cnt) ? sh_next : 0;
      sh_next = (t + 1 >= cnt) ? 0 : t + 1;
      r.src = t[2:0];
      hd = sh_head[t];
      tl = sh_tail[t];
      if (hd == tl) begin
        hd = 0;
        tl = 0;
      end else if (tl == QD && hd > 0) begin
        for (int i = 0; i < int'(tl - hd); i++) sh_store[t][i] = sh_store[t][hd + i];
        tl = tl - hd;
        hd = 0;
      end
      sh_head[t] = hd;
      sh_tail[t] = tl;
      if (tl >= QD) begin
        r.status = ST_FULL;
      end else begin
        sh_store[t][tl] = rq.handle;
        sh_tail[t] = tl + 1;
        r.status = ST_ACCEPTED;
        if (sh_pending < 255) sh_pending++;
      end
    end else if (rq.kind == K_FETCH) begin
      if (rq.wid < cnt) begin
        if (sh_tail[rq.wid] > sh_head[rq.wid]) begin
          sh_tail[rq.wid]--;
          r.task_val = sh_store[rq.wid][sh_tail[rq.wid]];
          r.status = ST_OWN;
          r.src = rq.wid;
        end else if (cnt > 1) begin
          x = sh_rng[rq.wid];
          x ^= x << 13;
          x ^= x >> 7;
          x ^= x << 17;
          sh_rng[rq.wid] = x;
          st = 32'(x % 64'(cnt));
          for (int o = 0; o < int'(cnt); o++) begin
            v = (st + o) % cnt;
            if (v != rq.wid && sh_head[v] < sh_tail[v]) begin
              r.task_val = sh_store[v][sh_head[v]];
              sh_head[v]++;
              r.status = ST_STOLEN;
              r.src = v[2:0];
              break;
            end
          end
        end
      end
    end else if (rq.kind == K_FINISH) begin
      if (sh_pending == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        sh_pending--;
        r.status = ST_DONE;
        r.done = (sh_pending == 0);
      end
    end
    r.pending = sh_pending[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      kind <= K_SUBMIT;
      worker_id <= 0;
      task_handle <= 0;
      in_gap <= 0;
    end else begin
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_reqs.size() != 0) begin
          sched_req_t rq;
          rq = pending_reqs.pop_front();
          in_valid <= 1;
          kind <= rq.kind;
          worker_id <= rq.wid;
          task_handle <= rq.handle;
          expected_rsps.push_back(schedule_item(rq));
          if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 15);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 0;
      out_gap <= 0;
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result status", 32'(status), 32'(0));
        end else begin
          sched_rsp_t e;
          e = expected_rsps.pop_front();
          if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
          if (task_out !== e.task_val) report_mismatch("task_out", task_out, e.task_val);
          if (source_worker !== e.src)
            report_mismatch("source_worker", 32'(source_worker), 32'(e.src));
          if (pending_count !== e.pending)
            report_mismatch("pending_count", 32'(pending_count), 32'(e.pending));
          if (all_done !== e.done) report_mismatch("all_done", 32'(all_done), 32'(e.done));
          if (e.status == ST_STOLEN) steals++;
          if (e.status == ST_FULL) fulls++;
          checked++;
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 15);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit");
      $display("simulation failed");
      $finish;
    end
  end

  function automatic sched_req_t mk(logic [1:0] k, logic [2:0] w, logic [31:0] h);
    sched_req_t rq;
    rq.kind = k;
    rq.wid = w;
    rq.handle = h;
    return rq;
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || in_valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_workers(logic [3:0] n);
    cfg_valid <= 1;
    cfg_workers <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sh_workers = n;
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned p;
    logic [2:0] w;
    for (int i = 0; i < int'(n); i++) begin
      p = $urandom_range(0, 99);
      w = $urandom_range(0, 7);
      // mostly submit and fetch, some finishes, rare unknown kind
      if (p < 42) pending_reqs.push_back(mk(K_SUBMIT, w, $urandom));
      else if (p < 80) pending_reqs.push_back(mk(K_FETCH, w, $urandom));
      else if (p < 97) pending_reqs.push_back(mk(K_FINISH, w, $urandom));
      else pending_reqs.push_back(mk(2'd3, w, $urandom));
    end
  endtask

  initial begin
    logic [3:0] phase_workers [6];
    phase_workers = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd5, 4'd8};
    for (int w = 0; w < NW; w++) begin
      sh_head[w] = 0;
      sh_tail[w] = 0;
      sh_rng[w] = RNG_SEED_BASIS ^ 64'(w + 1);
    end
    sh_next = 0;
    sh_pending = 0;
    sh_workers = 4'd8;
    errors = 0; checked = 0; steals = 0; fulls = 0;
    calm = 0;
    cfg_valid = 0;
    cfg_workers = 4'd8;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: underflow, extremes, own pop, steal, unknown kind, no work
    pending_reqs.push_back(mk(K_FINISH, 0, 0));
    pending_reqs.push_back(mk(K_SUBMIT, 7, 32'hffff_ffff));
    pending_reqs.push_back(mk(K_SUBMIT, 0, 32'h0));
    pending_reqs.push_back(mk(K_FETCH, 0, 0));
    pending_reqs.push_back(mk(K_FETCH, 0, 0));
    pending_reqs.push_back(mk(K_FETCH, 7, 0));
    pending_reqs.push_back(mk(2'd3, 7, 32'h5a5a_a5a5));
    pending_reqs.push_back(mk(K_FINISH, 0, 0));
    pending_reqs.push_back(mk(K_FINISH, 0, 0));
    drain();
    // single worker: fill to full, then a fetch from an inactive worker gives no work
    write_workers(4'd1);
    for (int i = 0; i < 17; i++) pending_reqs.push_back(mk(K_SUBMIT, 0, 32'(i * 3 + 1)));
    pending_reqs.push_back(mk(K_FETCH, 3, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_workers(phase_workers[ph]);
      if (ph == 5) calm = 1;
      queue_random(RANDOM_ITEMS / 6);
      drain();
    end

    $display("%0d results checked over worker counts 0..15, %0d steals, %0d full rejects",
             checked, steals, fulls);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### work_stealing_task_scheduler.f
hdl/wst_pkg.sv
hdl/wst_mod_unit.sv
hdl/wst_task_ram.sv
hdl/work_stealing_task_scheduler.sv
tb/work_stealing_task_scheduler_tb.sv
